// ===== src/terrain_shadow_ray_sweep_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the terrain shadow ray sweep unit
// Shared clocking and reset for the concurrent checks of the project.
// ---------------------------------------------------------------------------
`ifndef TERRAIN_SHADOW_RAY_SWEEP_UNIT_ASSERT_SVH
`define TERRAIN_SHADOW_RAY_SWEEP_UNIT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define TSRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define TSRS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== src/tsrs_pkg.sv =====
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep package
// Types and constants shared by the front, the back and the top level.
// ---------------------------------------------------------------------------
package tsrs_pkg;

	localparam int MaxSamples  = 64;
	localparam int SampleAw    = 6;
	localparam int CountW      = 7;
	localparam int GridAw      = 16;
	localparam int SectorW     = 9;
	localparam int SectorCount = 360;
	localparam int ValW        = 58;
	localparam int TotW        = 40;

	localparam logic [SectorW-1:0] NoSector   = 9'd511;
	localparam logic [SectorW-1:0] LastSector = 9'(SectorCount - 1);
	localparam logic [CountW-1:0]  CountMax   = 7'(MaxSamples);
	localparam logic signed [ValW-1:0] RmFloor = {1'b1, 57'd0};
	localparam logic [TotW-1:0]    TotMax     = '1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BEGIN = 2'd1,
		OP_CELL  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_LOOKUP,
		BK_SWEEP,
		BK_FINISH
	} bk_state_t;

	typedef struct packed {
		op_t                 op;
		logic [SampleAw-1:0] slot;
		logic [31:0]         tangent;
		logic [23:0]         weight;
		logic [CountW-1:0]   count;
		logic [SectorW-1:0]  sector;
		logic [GridAw-1:0]   cell_idx;
		logic signed [23:0]  height_value;
		logic [23:0]         distance;
		logic                nodata;
		logic                ray_first;
	} cmd_t;

	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} q_head_t;

	typedef struct packed {
		logic clear_busy;
	} bk_stat_t;

endpackage

// ===== src/tsrs_if.sv =====
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep channels
// Valid/ready channels for command beats and for result beats.
// ---------------------------------------------------------------------------
interface tsrs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [5:0]         slot;
	logic [31:0]        tangent;
	logic [23:0]        weight;
	logic [6:0]         active_count;
	logic [8:0]         sector_number;
	logic [15:0]        cell_req;
	logic signed [23:0] height_value;
	logic [23:0]        distance;
	logic               nodata;
	logic               ray_first;

	modport source (output valid, operation, slot, tangent, weight, active_count,
		sector_number, cell_req, height_value, distance, nodata, ray_first,
		input ready);
	modport sink (input valid, operation, slot, tangent, weight, active_count,
		sector_number, cell_req, height_value, distance, nodata, ray_first,
		output ready);
endinterface

interface tsrs_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] cell_out;
	logic [39:0] accumulated;
	logic        evaluated;

	modport source (output valid, cell_out, accumulated, evaluated, input ready);
	modport sink (input valid, cell_out, accumulated, evaluated, output ready);
endinterface

// ===== src/tsrs_front.sv =====
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep front
// Accepts command beats, decodes and saturates them, and queues them.
// ---------------------------------------------------------------------------
`include "terrain_shadow_ray_sweep_unit_assert.svh"

module tsrs_front (
	input  logic               clk,
	input  logic               arst_n,
	tsrs_in_if.sink            req,
	input  logic               pop,
	input  tsrs_pkg::bk_stat_t stat,
	output tsrs_pkg::q_head_t  head
);
	import tsrs_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       push;

	// Decode the beat; out-of-range counts and sectors saturate here.
	always_comb begin
		cmd.op           = op_t'(req.operation);
		cmd.slot         = req.slot;
		cmd.tangent      = req.tangent;
		cmd.weight       = req.weight;
		cmd.count        = (req.active_count > CountMax) ? CountMax : req.active_count;
		cmd.sector       = (req.sector_number > LastSector) ? LastSector : req.sector_number;
		cmd.cell_idx     = req.cell_req;
		cmd.height_value = req.height_value;
		cmd.distance     = req.distance;
		cmd.nodata       = req.nodata;
		cmd.ray_first    = req.ray_first;
	end

	assign req.ready = (cnt_q != 2'd2) && !stat.clear_busy;
	assign push      = req.valid && req.ready;
	assign head.vld  = (cnt_q != 2'd0);
	assign head.cmd  = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`TSRS_ASSERT(a_fifo_bound, (cnt_q != 2'd3), "queue count out of range")
	`TSRS_ASSERT(a_pop_nonempty, (pop |-> (cnt_q != 2'd0)), "pop from empty queue")
endmodule

// ===== src/tsrs_back.sv =====
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep back
// Sample stores, running maxima, grid stores and the per-sample sweep.
// ---------------------------------------------------------------------------
`include "terrain_shadow_ray_sweep_unit_assert.svh"

module tsrs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tsrs_pkg::q_head_t  head,
	output logic               pop,
	output tsrs_pkg::bk_stat_t stat,
	tsrs_out_if.source         rsp
);
	import tsrs_pkg::*;

	bk_state_t state_q, state_d;

	logic [31:0]            tan_mem [MaxSamples];
	logic [23:0]            w_mem   [MaxSamples];
	logic signed [ValW-1:0] rm_mem  [MaxSamples];
	logic [TotW-1:0]        tot_mem [2**GridAw];
	logic [SectorW-1:0]     mark_mem[2**GridAw];

	logic [31:0]            tan_rd;
	logic [23:0]            w_rd;
	logic signed [ValW-1:0] rm_rd;
	logic [TotW-1:0]        tot_rd;
	logic [SectorW-1:0]     mark_rd;

	logic [CountW-1:0]     n_q;
	logic [SectorW-1:0]    sector_q;
	logic [MaxSamples-1:0] rmv_q;
	logic [GridAw-1:0]     clr_q;
	logic [CountW-1:0]     k_q;
	cmd_t                  cur_q;
	logic [TotW-1:0]       total_q;
	logic                  test_q;

	logic                   s1_vld, s2_vld, s3_vld;
	logic [SampleAw-1:0]    idx_s1, idx_s2, idx_s3;
	logic [55:0]            prod_s2;
	logic [23:0]            w_s2, w_s3;
	logic signed [ValW-1:0] rm_s2, rm_s3, v_s3;

	logic                   res_vld_q;
	logic [GridAw-1:0]      res_cell_q;
	logic [TotW-1:0]        res_tot_q;
	logic                   res_ev_q;

	logic                   ld_we, g_we, issue, fire, sweep_done, rm_we, shadow;
	logic [GridAw-1:0]      g_waddr;
	logic [TotW-1:0]        g_wtot;
	logic [SectorW-1:0]     g_wmark;
	logic signed [ValW-1:0] zs;
	logic [TotW:0]          tot_sum;

	assign fire       = (state_q == BK_FINISH) && (!res_vld_q || rsp.ready);
	assign issue      = (state_q == BK_SWEEP) && (k_q < n_q);
	assign sweep_done = (k_q == n_q) && !s1_vld && !s2_vld && !s3_vld;
	assign zs         = {{18{cur_q.height_value[23]}}, cur_q.height_value, 16'd0};
	assign shadow     = rm_s3 > v_s3;
	assign rm_we      = s3_vld && (v_s3 > rm_s3);
	assign tot_sum    = {1'b0, total_q} + {17'd0, w_s3};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_q == '1) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (head.vld && (head.cmd.op == OP_CELL || head.cmd.op == OP_READ)) begin
					state_d = BK_LOOKUP;
				end
			end
			BK_LOOKUP: begin
				state_d = (cur_q.op == OP_CELL && !cur_q.nodata) ? BK_SWEEP : BK_FINISH;
			end
			BK_SWEEP: begin
				if (sweep_done) state_d = BK_FINISH;
			end
			BK_FINISH: begin
				if (fire) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control outputs and store write ports
	always_comb begin
		pop     = 1'b0;
		ld_we   = 1'b0;
		g_we    = 1'b0;
		g_waddr = cur_q.cell_idx;
		g_wtot  = total_q;
		g_wmark = sector_q;
		unique case (state_q)
			BK_CLEAR: begin
				g_we    = 1'b1;
				g_waddr = clr_q;
				g_wtot  = '0;
				g_wmark = NoSector;
			end
			BK_IDLE: begin
				pop   = head.vld;
				ld_we = head.vld && (head.cmd.op == OP_LOAD);
			end
			BK_FINISH: begin
				g_we = fire && test_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.clear_busy = (state_q == BK_CLEAR);

	always_ff @(posedge clk) begin
		if (ld_we) begin
			tan_mem[head.cmd.slot] <= head.cmd.tangent;
			w_mem[head.cmd.slot]   <= head.cmd.weight;
		end
		tan_rd <= tan_mem[k_q[SampleAw-1:0]];
		w_rd   <= w_mem[k_q[SampleAw-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rm_we) begin
			rm_mem[idx_s3] <= v_s3;
		end
		rm_rd <= rm_mem[k_q[SampleAw-1:0]];
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			tot_mem[g_waddr]  <= g_wtot;
			mark_mem[g_waddr] <= g_wmark;
		end
		tot_rd  <= tot_mem[head.cmd.cell_idx];
		mark_rd <= mark_mem[head.cmd.cell_idx];
	end

	// Sweep pipeline payload and per-item payload
	always_ff @(posedge clk) begin
		idx_s1  <= k_q[SampleAw-1:0];
		prod_s2 <= 56'(cur_q.distance) * 56'(tan_rd);
		w_s2    <= w_rd;
		rm_s2   <= rmv_q[idx_s1] ? rm_rd : RmFloor;
		idx_s2  <= idx_s1;
		v_s3    <= zs - {2'b00, prod_s2};
		w_s3    <= w_s2;
		rm_s3   <= rm_s2;
		idx_s3  <= idx_s2;
		if (pop) begin
			cur_q <= head.cmd;
		end
		if (state_q == BK_LOOKUP) begin
			total_q <= tot_rd;
			test_q  <= (cur_q.op == OP_CELL) && !cur_q.nodata && (mark_rd != sector_q);
		end else if (s3_vld && test_q && shadow) begin
			total_q <= tot_sum[TotW] ? TotMax : tot_sum[TotW-1:0];
		end
		if (fire) begin
			res_cell_q <= cur_q.cell_idx;
			res_tot_q  <= total_q;
			res_ev_q   <= test_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			n_q       <= '0;
			sector_q  <= '0;
			rmv_q     <= '0;
			clr_q     <= '0;
			k_q       <= '0;
			s1_vld    <= 1'b0;
			s2_vld    <= 1'b0;
			s3_vld    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop && head.cmd.op == OP_BEGIN) begin
				n_q      <= head.cmd.count;
				sector_q <= head.cmd.sector;
				rmv_q    <= '0;
				k_q      <= '0;
			end else if (pop && head.cmd.op == OP_CELL) begin
				k_q <= '0;
				if (head.cmd.ray_first || head.cmd.nodata) begin
					rmv_q <= '0;
				end
			end else begin
				if (issue) begin
					k_q <= k_q + 1'b1;
				end
				if (rm_we) begin
					rmv_q[idx_s3] <= 1'b1;
				end
			end
			s1_vld <= issue;
			s2_vld <= s1_vld;
			s3_vld <= s2_vld;
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = res_vld_q;
	assign rsp.cell_out    = res_cell_q;
	assign rsp.accumulated = res_tot_q;
	assign rsp.evaluated   = res_ev_q;

	`TSRS_ASSERT(a_no_rsp_in_clear, ((state_q == BK_CLEAR) |-> !res_vld_q), "result during clear")
	`TSRS_ASSERT(a_k_bound, (k_q <= n_q), "sample index beyond active count")
	`TSRS_ASSERT(a_s3_in_sweep, (s3_vld |-> (state_q == BK_SWEEP)), "sweep stage outside sweep")
	`TSRS_ASSERT_NEXT(a_fire_valid, fire, res_vld_q, "result register not loaded")
endmodule

// ===== src/terrain_shadow_ray_sweep_unit.sv =====
// Ray cell: one sample a cycle passes through the shared multiplier.
// Read accumulator: lookup, then the result register; load and begin sector act in idle.
// Throughput is set by the per-sample sweep loop; one command is worked at a time.
// After reset a clearing pass empties the grid stores; no beat is taken then.
// Reset is asynchronous and active low; control state clears at once.
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep unit
// Per-sector terrain shadowing engine with a decoupled front and back.
// ---------------------------------------------------------------------------
module terrain_shadow_ray_sweep_unit (
	input  logic       clk,
	input  logic       arst_n,
	tsrs_in_if.sink    req,
	tsrs_out_if.source rsp
);
	import tsrs_pkg::*;

	// The front decodes command beats and holds up to two of them, so the
	// requester is released while the back is still sweeping samples.
	q_head_t  head;
	logic     pop;
	bk_stat_t stat;

	tsrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.pop    (pop),
		.stat   (stat),
		.head   (head)
	);

	// The back owns all stores. A ray cell looks up the cell total and its
	// visit mark, sweeps every active sample unless it is nodata (read,
	// multiply, subtract, compare), then writes the total back if the cell was
	// tested, and loads the result register, which parts it from the result channel.
	tsrs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.stat   (stat),
		.rsp    (rsp)
	);
endmodule

// ===== tb/terrain_shadow_ray_sweep_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep checker
// Watches both channels, predicts each result beat and compares it.
// ---------------------------------------------------------------------------
module terrain_shadow_ray_sweep_checker
	import tsrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsrs_in_if   req,
	tsrs_out_if  rsp,
	output int   fails,
	output int   pending,
	output int   results_seen,
	output int   tested_cells
);

	typedef struct {
		logic [GridAw-1:0]  cell_idx;
		logic [TotW-1:0]    total;
		logic               tested;
	} shade_t;

	localparam longint MinusInf = -(longint'(1) <<< 57);

	logic [31:0]        sun_tan [MaxSamples];
	logic [23:0]        sun_wt  [MaxSamples];
	int                 live_samples;
	logic [SectorW-1:0] sweep_sector;
	longint             horizon [MaxSamples];
	logic [TotW-1:0]    shade_total [1 << GridAw];
	logic [SectorW-1:0] seen_in [1 << GridAw];
	shade_t             shade_q [$];

	function automatic void drop_horizons();
		for (int k = 0; k < MaxSamples; k++) horizon[k] = MinusInf;
	endfunction

	function automatic void predict_beat();
		shade_t     e;
		longint     zs;
		longint     v;
		logic [40:0] sum;
		logic       hit;
		e.cell_idx = req.cell_req;
		e.tested   = 1'b0;
		case (op_t'(req.operation))
			OP_LOAD: begin
				sun_tan[req.slot] = req.tangent;
				sun_wt[req.slot]  = req.weight;
				return;
			end
			OP_BEGIN: begin
				live_samples = (req.active_count > MaxSamples) ? MaxSamples
					: int'(req.active_count);
				sweep_sector = (req.sector_number > LastSector) ? LastSector
					: req.sector_number;
				drop_horizons();
				return;
			end
			OP_READ: ;
			default: begin
				if (req.ray_first || req.nodata) drop_horizons();
				if (!req.nodata) begin
					hit = (seen_in[req.cell_req] != sweep_sector);
					if (hit) seen_in[req.cell_req] = sweep_sector;
					zs = longint'(req.height_value) * 65536;
					for (int k = 0; k < live_samples; k++) begin
						v = zs - longint'(req.distance) * longint'(sun_tan[k]);
						if (hit && horizon[k] > v) begin
							sum = {1'b0, shade_total[req.cell_req]} + sun_wt[k];
							shade_total[req.cell_req] = sum[40] ? TotMax : sum[39:0];
						end
						if (v > horizon[k]) horizon[k] = v;
					end
					e.tested = hit;
				end
			end
		endcase
		e.total = shade_total[req.cell_req];
		shade_q.insert(shade_q.size(), e);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxSamples; i++) begin
				sun_tan[i] = '0;
				sun_wt[i]  = '0;
			end
			for (int i = 0; i < (1 << GridAw); i++) begin
				shade_total[i] = '0;
				seen_in[i]     = NoSector;
			end
			live_samples = 0;
			sweep_sector = '0;
			drop_horizons();
			shade_q.delete();
			fails        = 0;
			pending      = 0;
			results_seen = 0;
			tested_cells = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				results_seen++;
				if (shade_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result beat for cell %0d", $realtime,
							rsp.cell_out);
				end else begin
					shade_t e;
					e = shade_q.pop_front();
					if (e.tested) tested_cells++;
					if (rsp.cell_out !== e.cell_idx || rsp.accumulated !== e.total
							|| rsp.evaluated !== e.tested) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch exp cell %0d acc %0d ev %0b, got cell %0d acc %0d ev %0b",
								$realtime, e.cell_idx, e.total, e.tested, rsp.cell_out,
								rsp.accumulated, rsp.evaluated);
					end
				end
			end
			if (req.valid && req.ready) predict_beat();
			pending = shade_q.size();
		end
	end

endmodule

// ===== tb/terrain_shadow_ray_sweep_unit_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Terrain shadow ray sweep unit testbench
// Directed edge cases, then random sectors of far-to-near rays with random
// idling on both channels; a side checker predicts and compares every result beat.
// ---------------------------------------------------------------------------
module terrain_shadow_ray_sweep_unit_test;
	import tsrs_pkg::*;

	localparam int ItemTarget = 650;
	localparam int IdleLimit  = 300000;

	logic clk;
	logic arst_n;
	int   fails, pending, results_seen, tested_cells;
	int   beats_sent;
	int   quiet_cycles;
	bit   calm;

	tsrs_in_if  req ();
	tsrs_out_if rsp ();

	terrain_shadow_ray_sweep_unit DUT (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	terrain_shadow_ray_sweep_checker shadow_check (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .fails(fails),
		.pending(pending), .results_seen(results_seen), .tested_cells(tested_cells)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side stalls at random, except during the calm stretch.
	always @(negedge clk) rsp.ready <= calm || ($urandom_range(99) >= 31);

	// Watchdog: cycles without any beat on either channel. The limit covers the quiet
	// clearing pass after reset with margin.
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic cmd_t noise_cmd();
		cmd_t c;
		c.op           = op_t'(2'($urandom_range(3)));
		c.slot         = 6'($urandom_range(63));
		c.tangent      = $urandom;
		c.weight       = 24'($urandom);
		c.count        = 7'($urandom_range(127));
		c.sector       = 9'($urandom_range(511));
		c.cell_idx     = 16'($urandom);
		c.height_value = 24'($urandom);
		c.distance     = 24'($urandom);
		c.nodata       = 1'($urandom_range(1));
		c.ray_first    = 1'($urandom_range(1));
		return c;
	endfunction

	// Sends one command beat; valid stays high across back-to-back beats.
	task automatic put_beat(input cmd_t c);
		while (!calm && $urandom_range(99) < 31) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.operation     <= c.op;
		req.slot          <= c.slot;
		req.tangent       <= c.tangent;
		req.weight        <= c.weight;
		req.active_count  <= c.count;
		req.sector_number <= c.sector;
		req.cell_req      <= c.cell_idx;
		req.height_value  <= c.height_value;
		req.distance      <= c.distance;
		req.nodata        <= c.nodata;
		req.ray_first     <= c.ray_first;
		req.valid         <= 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic load_slot(input int s, input logic [31:0] t, input logic [23:0] w);
		cmd_t c;
		c         = noise_cmd();
		c.op      = OP_LOAD;
		c.slot    = 6'(s);
		c.tangent = t;
		c.weight  = w;
		put_beat(c);
	endtask

	task automatic begin_sector(input int n, input int sec);
		cmd_t c;
		c        = noise_cmd();
		c.op     = OP_BEGIN;
		c.count  = 7'(n);
		c.sector = 9'(sec);
		put_beat(c);
	endtask

	task automatic ray_cell(input op_t op, input int cell_no, input logic [23:0] z,
			input logic [23:0] p, input bit nd, input bit first);
		cmd_t c;
		c              = noise_cmd();
		c.op           = op;
		c.cell_idx     = 16'(cell_no);
		c.height_value = z;
		c.distance     = p;
		c.nodata       = nd;
		c.ray_first    = first;
		put_beat(c);
	endtask

	// One ray, far to near, over a small pool of cells so that revisits occur.
	task automatic sweep_ray();
		int  len;
		int  p;
		int  cell_no;
		len = $urandom_range(3, 10);
		p   = $urandom_range(100000, 4000000);
		for (int i = 0; i < len; i++) begin
			cell_no = ($urandom_range(19) == 0) ? $urandom_range(65535) : $urandom_range(47);
			ray_cell(OP_CELL, cell_no, 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20)),
				24'(p), $urandom_range(15) == 0, i == 0);
			p = p - $urandom_range(0, p / 4);
		end
	endtask

	initial begin
		int  pick;
		bit  drained_once;
		arst_n       = 1'b0;
		calm         = 1'b0;
		beats_sent   = 0;
		drained_once = 1'b0;
		req.valid    = 1'b0;
		{req.operation, req.slot, req.tangent, req.weight, req.active_count,
			req.sector_number, req.cell_req, req.height_value, req.distance,
			req.nodata, req.ray_first} = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: field extremes, empty sector, revisits, nodata, reads.
		load_slot(0, 32'h0, 24'hFFFFFF);
		load_slot(1, 32'hFFFFFFFF, 24'h1);
		load_slot(2, 32'h0001_0000, 24'h01_0000);
		load_slot(3, 32'h0000_8000, 24'h80_0000);
		begin_sector(0, 400);
		ray_cell(OP_CELL, 5, 24'h7FFFFF, 24'h0, 1'b0, 1'b1);
		ray_cell(OP_CELL, 5, 24'h800000, 24'hFFFFFF, 1'b0, 1'b0);
		begin_sector(4, 0);
		ray_cell(OP_CELL, 0, 24'h7FFFFF, 24'h0, 1'b0, 1'b1);
		ray_cell(OP_CELL, 1, 24'h800000, 24'hFFFFFF, 1'b0, 1'b0);
		ray_cell(OP_CELL, 1, 24'h000000, 24'h000100, 1'b0, 1'b0);
		ray_cell(OP_CELL, 65535, 24'h000000, 24'h000100, 1'b0, 1'b0);
		ray_cell(OP_CELL, 2, 24'h000000, 24'h000100, 1'b1, 1'b0);
		ray_cell(OP_CELL, 3, 24'h800000, 24'h000100, 1'b0, 1'b0);
		ray_cell(OP_CELL, 4, 24'h7FFFFF, 24'hFFFFFF, 1'b0, 1'b1);
		ray_cell(OP_READ, 1, 24'h0, 24'h0, 1'b0, 1'b0);
		ray_cell(OP_READ, 65535, 24'h0, 24'h0, 1'b0, 1'b0);
		begin_sector(4, 359);
		ray_cell(OP_CELL, 1, 24'h7FFFFF, 24'h0, 1'b0, 1'b1);
		ray_cell(OP_CELL, 1, 24'h800000, 24'h000100, 1'b0, 1'b0);

		// Every slot is written before any random sector can make it active.
		for (int s = 0; s < MaxSamples; s++)
			load_slot(s, ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 3 << 16),
				24'($urandom));
		begin_sector(127, 511);
		sweep_ray();

		while (beats_sent < ItemTarget) begin
			calm = (beats_sent >= 300 && beats_sent < 400);
			if (!drained_once && beats_sent >= 450) begin
				// Hold the sender until every outstanding result has come back.
				req.valid <= 1'b0;
				while (pending != 0) @(posedge clk);
				@(negedge clk);
				drained_once = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 10)
				load_slot($urandom_range(63),
					($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 3 << 16),
					24'($urandom));
			else if (pick < 18)
				begin_sector(($urandom_range(9) == 0) ? $urandom_range(64, 127)
					: $urandom_range(0, 8), $urandom_range(511));
			else if (pick < 24)
				ray_cell(OP_READ, ($urandom_range(3) == 0) ? $urandom_range(65535)
					: $urandom_range(47), 24'h0, 24'h0, 1'b0, 1'b0);
			else if (pick < 28)
				put_beat(noise_cmd());
			else
				sweep_ray();
		end
		calm = 1'b0;
		req.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d command beats; %0d result beats checked, %0d of them first tests",
			beats_sent, results_seen, tested_cells);
		$display("of a cell in its sector, with random idling and a full drain midway.");
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
